// ----- design/swfd_pkg.sv -----
// Package for the sliding window frame detector: register map, reset values, sizes.
`default_nettype none
package swfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned WIDX_W      = 3;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned WORD_BYTES  = WORD_W / BYTE_W;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned NUM_KINDS   = 3;
  localparam int unsigned MAX_RESULTS = 10;

  localparam int unsigned DEF_LEFT_FRAME_LEN  = 23;
  localparam int unsigned DEF_RIGHT_FRAME_LEN = 40;
  localparam int unsigned DEF_AIR_FRAME_LEN   = 15;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TYPE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TYPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_TYPE     = 3'd4;

  localparam logic [BYTE_W-1:0] RST_START_MARKER = 8'd65;
  localparam logic [BYTE_W-1:0] RST_END_MARKER   = 8'd90;
  localparam logic [BYTE_W-1:0] RST_LEFT_TYPE    = 8'd240;
  localparam logic [BYTE_W-1:0] RST_RIGHT_TYPE   = 8'd241;
  localparam logic [BYTE_W-1:0] RST_AIR_TYPE     = 8'd242;

  // frame kind codes
  localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_AIR   = 2'd2;

  // stream packing
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 3;

endpackage
`default_nettype wire

// ----- design/sliding_window_frame_detector.sv -----
// Sliding window frame detector: byte window, frame match and payload word emitter.
//
// Bytes enter on the in_ stream, one per transaction, and shift into a window as deep as the
// longest frame. Right after a byte enters, the left, right and air frame kinds are checked
// against the start marker, type code and end marker; each match sends its payload (the bytes
// between type code and end marker) as 64-bit little-endian words on the out_ stream, left
// first, then right, then air. A byte that completes no frame is simply taken; a byte that
// starts result words is taken first, and then the word emitter puts out one word per cycle
// while the sink is ready and holds in_tready low until the last word of the run sits in
// the output register. A sink that holds off stalls the emitter. Results are capped at ten
// per byte. Configuration writes on cfg_ take effect at once and are always ready; they
// belong in idle time between runs.
`default_nettype none
module sliding_window_frame_detector #(
  parameter int unsigned LEFT_FRAME_LEN  = swfd_pkg::DEF_LEFT_FRAME_LEN,
  parameter int unsigned RIGHT_FRAME_LEN = swfd_pkg::DEF_RIGHT_FRAME_LEN,
  parameter int unsigned AIR_FRAME_LEN   = swfd_pkg::DEF_AIR_FRAME_LEN
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input stream
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [swfd_pkg::IN_TDATA_W-1:0]       in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [2:0] word_index, [66:3] payload_word, [70:67] byte_count, [71] zero
  output logic [swfd_pkg::OUT_TDATA_W-1:0]           out_tdata,
  output logic [swfd_pkg::OUT_TUSER_W-1:0]           out_tuser,  // [1:0] frame_kind, [2] frame_last
  output logic                                       out_tlast,  // run_last
  // configuration write
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [swfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [swfd_pkg::BYTE_W-1:0]           cfg_data
);
  import swfd_pkg::*;

  localparam int unsigned MAX_LEN_LR = (LEFT_FRAME_LEN > RIGHT_FRAME_LEN) ?
                                       LEFT_FRAME_LEN : RIGHT_FRAME_LEN;
  localparam int unsigned WIN   = (MAX_LEN_LR > AIR_FRAME_LEN) ? MAX_LEN_LR : AIR_FRAME_LEN;
  localparam int unsigned MAXP  = WIN - 3;
  localparam int unsigned NB    = (MAXP > WORD_BYTES) ? MAXP : WORD_BYTES;
  localparam int unsigned BUFW  = NB * BYTE_W;
  localparam int unsigned PLW   = $clog2(MAXP + 1) + 1;
  localparam int unsigned RCW   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned FLEN [NUM_KINDS] = '{LEFT_FRAME_LEN, RIGHT_FRAME_LEN, AIR_FRAME_LEN};
  localparam logic [PLW-1:0] WORD_BYTES_P = PLW'(WORD_BYTES);
  localparam logic [RCW-1:0] LAST_RES     = RCW'(MAX_RESULTS - 1);

  // configuration registers
  logic [BYTE_W-1:0] start_mark_r, end_mark_r;
  logic [BYTE_W-1:0] type_code_r [NUM_KINDS];

  // window: win_r[0] is the newest byte
  logic [BYTE_W-1:0] win_r   [WIN];
  logic [BYTE_W-1:0] win_nxt [WIN];

  logic [NUM_KINDS-1:0] match_r, match_nxt, hit;
  logic [WIDX_W-1:0]    widx_r, widx_nxt;
  logic [PLW-1:0]       rem_r, rem_nxt, rem_src;
  logic [BUFW-1:0]      buf_r, buf_nxt, src;
  logic [RCW-1:0]       res_cnt_r, res_cnt_nxt;

  logic [BUFW-1:0]      pay [NUM_KINDS];
  logic [PLW-1:0]       plen [NUM_KINDS];

  logic                 busy, in_fire, emit_fire;
  logic [KIND_W-1:0]    cur_kind;
  logic                 first_word, w_frame_last, w_run_last;
  logic [CNT_W-1:0]     w_count;
  logic [NUM_KINDS-1:0] cur_bit;

  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    o_kind_r;
  logic [WIDX_W-1:0]    o_widx_r;
  logic [WORD_W-1:0]    o_word_r;
  logic [CNT_W-1:0]     o_count_r;
  logic                 o_flast_r, o_rlast_r;

  assign busy      = |match_r;
  assign in_tready = ~busy;
  assign in_fire   = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign emit_fire = busy & (~out_valid_r | out_tready);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mark_r   <= RST_START_MARKER;
      end_mark_r     <= RST_END_MARKER;
      type_code_r[0] <= RST_LEFT_TYPE;
      type_code_r[1] <= RST_RIGHT_TYPE;
      type_code_r[2] <= RST_AIR_TYPE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_MARKER: start_mark_r   <= cfg_data;
        REG_END_MARKER:   end_mark_r     <= cfg_data;
        REG_LEFT_TYPE:    type_code_r[0] <= cfg_data;
        REG_RIGHT_TYPE:   type_code_r[1] <= cfg_data;
        REG_AIR_TYPE:     type_code_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // window shift and frame match on the shifted window
  always_comb begin
    win_nxt[0] = in_tdata[BYTE_W-1:0];
    for (int i = 1; i < WIN; i++) win_nxt[i] = win_r[i-1];
  end

  generate
    for (genvar k = 0; k < NUM_KINDS; k++) begin : g_kind
      assign hit[k]  = (win_nxt[FLEN[k]-1] == start_mark_r) &&
                       (win_nxt[FLEN[k]-2] == type_code_r[k]) &&
                       (win_nxt[0] == end_mark_r);
      assign plen[k] = PLW'(FLEN[k] - 3);
      // payload byte j of this kind sits at fixed window tap FLEN-3-j
      for (genvar j = 0; j < NB; j++) begin : g_byte
        if (j < FLEN[k] - 3) begin : g_tap
          assign pay[k][j*BYTE_W +: BYTE_W] = win_r[FLEN[k]-3-j];
        end else begin : g_pad
          assign pay[k][j*BYTE_W +: BYTE_W] = '0;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) win_r[i] <= '0;
    end else if (in_fire) begin
      for (int i = 0; i < WIN; i++) win_r[i] <= win_nxt[i];
    end
  end

  // word emitter: first word of a kind comes straight from the window taps,
  // later words from the shifted remainder
  always_comb begin
    if (match_r[0]) begin
      cur_kind = KIND_LEFT;
      cur_bit  = 3'b001;
    end else if (match_r[1]) begin
      cur_kind = KIND_RIGHT;
      cur_bit  = 3'b010;
    end else begin
      cur_kind = KIND_AIR;
      cur_bit  = 3'b100;
    end
    first_word   = (widx_r == '0);
    src          = first_word ? pay[cur_kind] : buf_r;
    rem_src      = first_word ? plen[cur_kind] : rem_r;
    w_frame_last = (rem_src <= WORD_BYTES_P);
    w_count      = w_frame_last ? CNT_W'(rem_src) : CNT_W'(WORD_BYTES);
    w_run_last   = (w_frame_last && ((match_r & ~cur_bit) == '0)) || (res_cnt_r == LAST_RES);
  end

  always_comb begin
    match_nxt   = match_r;
    widx_nxt    = widx_r;
    rem_nxt     = rem_r;
    buf_nxt     = buf_r;
    res_cnt_nxt = res_cnt_r;
    if (in_fire) begin
      match_nxt   = hit;
      widx_nxt    = '0;
      res_cnt_nxt = '0;
    end else if (emit_fire) begin
      buf_nxt     = src >> WORD_W;
      rem_nxt     = rem_src - WORD_BYTES_P;
      res_cnt_nxt = res_cnt_r + RCW'(1);
      if (w_run_last) begin
        match_nxt = '0;
        widx_nxt  = '0;
      end else if (w_frame_last) begin
        match_nxt = match_r & ~cur_bit;
        widx_nxt  = '0;
      end else begin
        widx_nxt  = widx_r + WIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r   <= '0;
      widx_r    <= '0;
      res_cnt_r <= '0;
    end else begin
      match_r   <= match_nxt;
      widx_r    <= widx_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    buf_r <= buf_nxt;
  end

  // output register
  assign out_valid_nxt = emit_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      o_kind_r  <= cur_kind;
      o_widx_r  <= widx_r;
      o_word_r  <= src[WORD_W-1:0];
      o_count_r <= w_count;
      o_flast_r <= w_frame_last;
      o_rlast_r <= w_run_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, o_count_r, o_word_r, o_widx_r};
  assign out_tuser  = {o_flast_r, o_kind_r};
  assign out_tlast  = o_rlast_r;

  // the window must not move while a run is being emitted
  a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (win_r[0] == $past(win_r[0])))
    else $error("window shifted during emission");

  // a word that does not close its frame is a full word
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> (out_tdata[70:67] == CNT_W'(WORD_BYTES)))
    else $error("partial word before end of frame");

  // the run ends with the word that carries run_last
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && w_run_last) |=> !busy)
    else $error("emitter still busy after last word");

  // results never exceed the per-byte cap
  a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (res_cnt_r <= LAST_RES))
    else $error("result count past cap");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the sliding window frame detector: frames, overlaps, stalls.
`timescale 1ns / 100ps
module testbench;
  import swfd_pkg::*;

  localparam int HIST_DEPTH = 64;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WIDX_W-1:0] widx;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
    logic              flast;
    logic              rlast;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [2:0] word_index, [66:3] payload_word, [70:67] byte_count
  logic [OUT_TUSER_W-1:0] out_tuser;   // [1:0] frame_kind, [2] frame_last
  logic                   out_tlast;   // run_last
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [BYTE_W-1:0]      cfg_data = '0;

  logic [BYTE_W-1:0] rx_pending [$];
  frame_word_t       expected_words [$];
  logic [BYTE_W-1:0] recent_bytes [0:HIST_DEPTH-1];
  logic [BYTE_W-1:0] marker_regs [0:REG_AIR_TYPE];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  stall_cycles = 0;
  int  fail_count = 0;
  int  bytes_queued = 0;
  logic in_taken = 1'b0;

  sliding_window_frame_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int frame_len(int k);
    int len;
    case (k)
      0:       len = DEF_LEFT_FRAME_LEN;
      1:       len = DEF_RIGHT_FRAME_LEN;
      default: len = DEF_AIR_FRAME_LEN;
    endcase
    if (len < 4) len = 4;
    if (len > HIST_DEPTH) len = HIST_DEPTH;
    return len;
  endfunction

  function automatic logic [KIND_W-1:0] kind_code(int k);
    case (k)
      0:       return KIND_LEFT;
      1:       return KIND_RIGHT;
      default: return KIND_AIR;
    endcase
  endfunction

  // shift the byte in, then emit payload words of every matching kind, capped per byte
  function automatic void predict_payload_words(logic [BYTE_W-1:0] rx);
    frame_word_t run [$];
    frame_word_t w;
    int len, plen, pos, n, widx;
    for (int i = HIST_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = rx;
    for (int k = 0; k < NUM_KINDS; k++) begin
      len = frame_len(k);
      if (recent_bytes[len-1] == marker_regs[REG_START_MARKER] &&
          recent_bytes[len-2] == marker_regs[REG_LEFT_TYPE + k] &&
          recent_bytes[0] == marker_regs[REG_END_MARKER]) begin
        plen = len - 3;
        pos = 0;
        widx = 0;
        while (pos < plen && run.size() < MAX_RESULTS) begin
          n = plen - pos;
          if (n > WORD_BYTES) n = WORD_BYTES;
          w = '0;
          w.kind = kind_code(k);
          w.widx = widx[WIDX_W-1:0];
          for (int b = 0; b < n; b++) w.word[8*b +: 8] = recent_bytes[len - 3 - (pos + b)];
          pos += n;
          w.cnt = n[CNT_W-1:0];
          w.flast = (pos == plen);
          run.push_back(w);
          widx++;
        end
      end
    end
    if (run.size() > 0) run[run.size()-1].rlast = 1'b1;
    foreach (run[i]) expected_words.push_back(run[i]);
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] exp_v,
                                      logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // monitor: results are checked before the byte taken at this edge is predicted
  always @(posedge clk) begin : monitor
    frame_word_t e;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: kind %0d index %0d data %0h",
                 out_tuser[1:0], out_tdata[2:0], out_tdata[66:3]);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          check_field("frame_kind", WORD_W'(e.kind), WORD_W'(out_tuser[1:0]));
          check_field("word_index", WORD_W'(e.widx), WORD_W'(out_tdata[2:0]));
          check_field("payload_word", e.word, out_tdata[66:3]);
          check_field("byte_count", WORD_W'(e.cnt), WORD_W'(out_tdata[70:67]));
          check_field("frame_last", WORD_W'(e.flast), WORD_W'(out_tuser[2]));
          check_field("run_last", WORD_W'(e.rlast), WORD_W'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) predict_payload_words(in_tdata);
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (rx_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= rx_pending.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random backpressure and an optional long hold-off
  always @(negedge clk) begin
    out_tready <= (stall_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(negedge clk) begin
    if (stall_cycles > 0) stall_cycles <= stall_cycles - 1;
  end

  task automatic queue_byte(logic [BYTE_W-1:0] b);
    rx_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_frame(int k, bit broken);
    logic [BYTE_W-1:0] seq [$];
    int len, spoil;
    len = frame_len(k);
    seq.push_back(marker_regs[REG_START_MARKER]);
    seq.push_back(marker_regs[REG_LEFT_TYPE + k]);
    repeat (len - 3) seq.push_back(8'($urandom_range(255)));
    seq.push_back(marker_regs[REG_END_MARKER]);
    if (broken) begin
      case ($urandom_range(2))
        0:       spoil = 0;
        1:       spoil = 1;
        default: spoil = len - 1;
      endcase
      seq[spoil] = seq[spoil] + 8'($urandom_range(255, 1));
    end
    foreach (seq[i]) queue_byte(seq[i]);
  endtask

  // one span on which all three kinds end together
  task automatic push_overlap(bit extremes);
    logic [BYTE_W-1:0] seq [$];
    int span, first;
    span = 0;
    for (int k = 0; k < NUM_KINDS; k++) if (frame_len(k) > span) span = frame_len(k);
    for (int i = 0; i < span; i++) begin
      if (extremes) seq.push_back(i[0] ? 8'hFF : 8'h00);
      else seq.push_back(8'($urandom_range(255)));
    end
    for (int k = 0; k < NUM_KINDS; k++) begin
      first = span - frame_len(k);
      seq[first] = marker_regs[REG_START_MARKER];
      seq[first + 1] = marker_regs[REG_LEFT_TYPE + k];
    end
    seq[span - 1] = marker_regs[REG_END_MARKER];
    foreach (seq[i]) queue_byte(seq[i]);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(3))
        0:       queue_byte(marker_regs[REG_START_MARKER]);
        1:       queue_byte(marker_regs[REG_END_MARKER]);
        default: queue_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic run_random(int min_bytes);
    int bytes0, r;
    bytes0 = bytes_queued;
    while (bytes_queued - bytes0 < min_bytes) begin
      r = $urandom_range(99);
      if (r < 55) push_frame($urandom_range(NUM_KINDS - 1), 1'b0);
      else if (r < 70) push_frame($urandom_range(NUM_KINDS - 1), 1'b1);
      else if (r < 78) push_overlap(1'b0);
      else push_noise();
      while (rx_pending.size() >= 16) @(posedge clk);
    end
  endtask

  // sender stops until every byte is taken and every result word has arrived
  task automatic wait_idle();
    do @(posedge clk);
    while (rx_pending.size() > 0 || in_tvalid || expected_words.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx <= REG_AIR_TYPE) marker_regs[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [BYTE_W-1:0] start_v, logic [BYTE_W-1:0] end_v,
                           logic [BYTE_W-1:0] left_v, logic [BYTE_W-1:0] right_v,
                           logic [BYTE_W-1:0] air_v);
    write_reg(REG_START_MARKER, start_v);
    write_reg(REG_END_MARKER, end_v);
    write_reg(REG_LEFT_TYPE, left_v);
    write_reg(REG_RIGHT_TYPE, right_v);
    write_reg(REG_AIR_TYPE, air_v);
  endtask

  initial begin
    foreach (recent_bytes[i]) recent_bytes[i] = '0;
    marker_regs[REG_START_MARKER] = RST_START_MARKER;
    marker_regs[REG_END_MARKER]   = RST_END_MARKER;
    marker_regs[REG_LEFT_TYPE]    = RST_LEFT_TYPE;
    marker_regs[REG_RIGHT_TYPE]   = RST_RIGHT_TYPE;
    marker_regs[REG_AIR_TYPE]     = RST_AIR_TYPE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, then all three kinds matching on one end marker
    send_idle_pct = 36;
    recv_idle_pct = 79;
    queue_byte(8'h00);
    queue_byte(8'hFF);
    push_overlap(1'b1);
    wait_idle();

    write_all(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80);
    run_random(20);
    wait_idle();

    send_idle_pct = 79;
    recv_idle_pct = 36;
    write_all(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)));
    // indexes past the register map must be ignored
    for (int i = REG_AIR_TYPE + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], 8'($urandom_range(255)));
    run_random(20);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01);
    // long sink hold-off while bytes keep coming, so the input stalls
    @(posedge clk);
    stall_cycles = 300;
    push_overlap(1'b0);
    run_random(20);
    wait_idle();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sliding_window_frame_detector.f -----
design/swfd_pkg.sv
design/sliding_window_frame_detector.sv
sim/testbench.sv
